// File: sv/tsadc_pkg.sv
// Shared constants, payload types and control structs for the two-way data cache.
package tsadc_pkg;

    localparam int LINE_BYTES    = 16;
    localparam int WAYS          = 2;
    localparam int CACHE_BYTES   = 16384;
    localparam int MEM_ADDR_BITS = 16;

    localparam int NUM_LINES      = CACHE_BYTES / LINE_BYTES;
    localparam int NUM_SETS       = NUM_LINES / WAYS;
    localparam int WORDS_PER_LINE = LINE_BYTES / 8;
    localparam int MEM_WORDS      = (1 << MEM_ADDR_BITS) / 8;
    localparam int OFF_W          = $clog2(LINE_BYTES);
    localparam int SET_W          = $clog2(NUM_SETS);
    localparam int TAG_W          = MEM_ADDR_BITS - OFF_W - SET_W;
    localparam int WORD_W         = $clog2(MEM_WORDS);
    localparam int WAY_W          = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LINE_W         = LINE_BYTES * 8;
    localparam int CLR_W          = WORD_W + 1;

    localparam logic [1:0]  ACT_LOAD  = 2'd0;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [1:0]  size_code;
        logic [63:0] store_value;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [63:0] load_data;
    } rsp_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic lookup;
        logic wb_en;
        logic rd_en;
        logic word_sel;
        logic capture;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic hit;
        logic full;
        logic out_free;
    } sts_t;

endpackage

// File: sv/tsadc_ctrl.sv
// Sequencer for lookup, write-back, refill and update of one transaction.
module tsadc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tsadc_pkg::sts_t sts,
    output tsadc_pkg::cmd_t cmd
);
    import tsadc_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_LOOKUP = 8'b0000_0100,
        ST_WB0    = 8'b0000_1000,
        ST_WB1    = 8'b0001_0000,
        ST_RD0    = 8'b0010_0000,
        ST_RD1    = 8'b0100_0000,
        ST_UPDATE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                if (sts.hit) begin
                    state_next = ST_UPDATE;
                end else if (sts.full) begin
                    state_next = ST_WB0;
                end else begin
                    state_next = ST_RD0;
                end
            end
            ST_WB0: begin
                cmd.wb_en  = 1'b1;
                state_next = ST_WB1;
            end
            ST_WB1: begin
                cmd.wb_en    = 1'b1;
                cmd.word_sel = 1'b1;
                state_next   = ST_RD0;
            end
            ST_RD0: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_RD1;
            end
            ST_RD1: begin
                cmd.rd_en    = 1'b1;
                cmd.word_sel = 1'b1;
                cmd.capture  = 1'b1;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (sts.out_free) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

endmodule

// File: sv/tsadc_dpath.sv
// Tag, line and backing memories, replacement LFSR and result register.
module tsadc_dpath (
    input  logic              aclk,
    input  logic              aresetn,
    input  tsadc_pkg::req_t   s_payload,
    output tsadc_pkg::rsp_t   m_payload,
    output logic              m_valid,
    input  logic              m_ready,
    input  logic              cfg_valid,
    input  logic [15:0]       cfg_data,
    input  tsadc_pkg::cmd_t   cmd,
    output tsadc_pkg::sts_t   sts
);
    import tsadc_pkg::*;

    localparam int SLOT_W = TAG_W + 1;

    logic [WAYS*SLOT_W-1:0] tag_mem [NUM_SETS];
    logic [WAYS*LINE_W-1:0] line_mem [NUM_SETS];
    logic [63:0]            back_mem [MEM_WORDS];

    logic [WAYS*SLOT_W-1:0] tag_row_q;
    logic [WAYS*LINE_W-1:0] line_row_q;
    logic [63:0]            mem_q;

    req_t              req_reg;
    logic [WAY_W-1:0]  way_reg;
    logic              hit_reg;
    logic [63:0]       fill0_reg;
    logic [15:0]       lfsr_reg;
    logic [CLR_W-1:0]  clr_cnt_reg;
    logic              m_valid_reg;
    rsp_t              rsp_reg;

    logic [SET_W-1:0]  req_set;
    logic [TAG_W-1:0]  req_tag;
    logic [SET_W-1:0]  rd_set;
    logic [WAYS-1:0]   hit_vec;
    logic [WAYS-1:0]   valid_vec;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  inv_way;
    logic              any_hit;
    logic              all_valid;
    logic [15:0]       lfsr_step;
    logic [WAY_W-1:0]  victim_tag_way;
    logic [TAG_W-1:0]  victim_tag;
    logic [WORD_W-1:0] back_addr;
    logic [LINE_W-1:0] cur_line;
    logic [LINE_W-1:0] new_line;
    logic [OFF_W-1:0]  size_mask;
    logic [OFF_W-1:0]  off;
    logic [LINE_W-1:0] shifted;
    logic [63:0]       load_val;
    logic [63:0]       data_mask;
    logic [LINE_W-1:0] bit_mask;
    logic [LINE_W-1:0] placed;
    logic [WAYS*SLOT_W-1:0] new_tag_row;
    logic [WAYS*LINE_W-1:0] new_line_row;

    assign req_set = req_reg.address[OFF_W +: SET_W];
    assign req_tag = req_reg.address[OFF_W+SET_W +: TAG_W];
    assign rd_set  = s_payload.address[OFF_W +: SET_W];

    always_comb begin
        hit_vec = '0;
        valid_vec = '0;
        hit_way = '0;
        inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            valid_vec[w] = tag_row_q[w*SLOT_W + TAG_W];
            hit_vec[w]   = valid_vec[w] && (tag_row_q[w*SLOT_W +: TAG_W] == req_tag);
            if (hit_vec[w]) hit_way = WAY_W'(w);
            if (!valid_vec[w]) inv_way = WAY_W'(w);
        end
    end

    assign any_hit   = |hit_vec;
    assign all_valid = &valid_vec;
    assign lfsr_step = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : 16'h0000);
    assign victim_tag_way = way_reg;
    assign victim_tag = tag_row_q[victim_tag_way*SLOT_W +: TAG_W];

    always_comb begin
        if (cmd.clear) begin
            back_addr = clr_cnt_reg[WORD_W-1:0];
        end else if (cmd.wb_en) begin
            back_addr = {victim_tag, req_set, cmd.word_sel};
        end else begin
            back_addr = {req_tag, req_set, cmd.word_sel};
        end
    end

    // Line contents for the update: stored line on a hit, refilled words on a miss.
    always_comb begin
        cur_line  = hit_reg ? line_row_q[way_reg*LINE_W +: LINE_W] : {mem_q, fill0_reg};
        size_mask = OFF_W'((1 << req_reg.size_code) - 1);
        off       = req_reg.address[OFF_W-1:0] & ~size_mask;
        shifted   = cur_line >> {off, 3'b000};
        case (req_reg.size_code)
            2'd0:    data_mask = 64'h0000_0000_0000_00FF;
            2'd1:    data_mask = 64'h0000_0000_0000_FFFF;
            2'd2:    data_mask = 64'h0000_0000_FFFF_FFFF;
            default: data_mask = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        load_val = shifted[63:0] & data_mask;
        bit_mask = LINE_W'(data_mask) << {off, 3'b000};
        placed   = LINE_W'(req_reg.store_value) << {off, 3'b000};
        if (req_reg.action == ACT_LOAD) begin
            new_line = cur_line;
        end else begin
            new_line = (cur_line & ~bit_mask) | (placed & bit_mask);
        end
        new_tag_row  = tag_row_q;
        new_tag_row[way_reg*SLOT_W +: SLOT_W] = {1'b1, req_tag};
        new_line_row = line_row_q;
        new_line_row[way_reg*LINE_W +: LINE_W] = new_line;
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            tag_mem[clr_cnt_reg[SET_W-1:0]] <= '0;
        end else if (cmd.update) begin
            tag_mem[req_set] <= new_tag_row;
        end else if (cmd.accept) begin
            tag_row_q <= tag_mem[rd_set];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            line_mem[req_set] <= new_line_row;
        end else if (cmd.accept) begin
            line_row_q <= line_mem[rd_set];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            back_mem[back_addr] <= '0;
        end else if (cmd.wb_en) begin
            back_mem[back_addr] <= line_row_q[way_reg*LINE_W + {cmd.word_sel, 6'd0} +: 64];
        end else if (cmd.rd_en) begin
            mem_q <= back_mem[back_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) req_reg <= s_payload;
        if (cmd.capture) fill0_reg <= mem_q;
        if (cmd.update) begin
            rsp_reg.hit       <= hit_reg;
            rsp_reg.load_data <= (req_reg.action == ACT_LOAD) ? load_val : 64'd0;
        end
        if (cmd.lookup) begin
            hit_reg <= any_hit;
            if (any_hit) begin
                way_reg <= hit_way;
            end else if (!all_valid) begin
                way_reg <= inv_way;
            end else begin
                way_reg <= WAY_W'(lfsr_step % WAYS);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg    <= 16'd1;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                lfsr_reg <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
            end else if (cmd.lookup && !any_hit && all_valid) begin
                lfsr_reg <= lfsr_step;
            end
            if (cmd.clear && !clr_cnt_reg[CLR_W-1]) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.update) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.clear_done = clr_cnt_reg[CLR_W-1];
    assign sts.hit        = any_hit;
    assign sts.full       = all_valid;
    assign sts.out_free   = !m_valid_reg || m_ready;
    assign m_valid        = m_valid_reg;
    assign m_payload      = rsp_reg;

endmodule

// File: sv/two_way_set_assoc_data_cache.sv
// Top level of the two-way set-associative write-back data cache.
// Usage: requests arrive on the s_ channel (valid/ready) as one packed
// transaction holding action, address, size and store data. Each request
// produces exactly one response transaction on the m_ channel carrying the
// hit flag and the zero-extended load data (zero for stores and modifies).
// The block works on one transaction at a time. A hit goes from lookup
// straight to the update; a miss into a free way first refills the line
// from the backing memory, and a miss that evicts a line first writes the
// victim back, both through the single port of the backing memory, which
// moves one 64-bit word per cycle for write-back and refill. The next
// request is accepted when the controller returns to idle after the update.
// The response sits in an output register, so a new request is accepted
// while the previous response waits; if the receiver stalls, the next
// transaction halts just before its update until the register frees.
// After reset a clearing pass zeroes the backing memory and
// the valid bits; no request is accepted during it, while writes to the
// replacement seed on the cfg_ channel are always taken. Writing a seed of
// zero loads the LFSR with one.
module two_way_set_assoc_data_cache (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tsadc_pkg::req_t s_payload,
    output logic            m_valid,
    input  logic            m_ready,
    output tsadc_pkg::rsp_t m_payload,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [15:0]     cfg_data
);
    import tsadc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // The seed register can be written in any cycle.
    assign cfg_ready = 1'b1;

    tsadc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tsadc_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .m_payload (m_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
